// ----- rtl/fpa_pkg.sv -----
// Shared types, command codes and constants of the fixed-point unit.
package fpa_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  // Quotient bits: magnitude of a, shifted by the fraction and one more for rounding
  localparam int QUOT_W        = DATA_W + FRACTION_BITS + 1;
  localparam int DIV_STEP      = 2;
  localparam int DIV_STAGES    = (QUOT_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [DATA_W-1:0] RAW_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] RAW_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic [PROD_W-1:0] MAG_MAX  = PROD_W'(RAW_MAX);
  localparam logic [PROD_W-1:0] MAG_MIN  = PROD_W'(RAW_MIN);

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_CMP      = 4'd6,
    CMD_INC      = 4'd7,
    CMD_DEC      = 4'd8,
    CMD_FROM_INT = 4'd9,
    CMD_TO_INT   = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  // Classified request, as it waits between front and back
  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] res;
    logic              ovf;
    logic              dz;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              neg;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
  } item_t;

  // One stage of the back pipeline
  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [DATA_W-1:0] res;
    logic              ovf;
    logic              dz;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic [DATA_W-1:0] rem;
    logic [QUOT_W-1:0] dq;
    logic [DATA_W-1:0] d;
  } pipe_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              ovf;
    logic              dz;
  } res_t;

endpackage

// ----- rtl/fpa_front.sv -----
// Front end: decodes a request, settles the simple commands and sets up mul and div.
module fpa_front (
  input  logic [3:0]                       command_i,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_b_i,
  output fpa_pkg::item_t                   item_o
);
  import fpa_pkg::*;

  logic signed [DATA_W:0]      sum;
  logic signed [DATA_W:0]      diff;
  logic signed [DATA_W:0]      incr;
  logic signed [DATA_W:0]      decr;
  logic [FRACTION_BITS:0]      top;
  cmd_e                        cmd;

  // Saturate a one-bit-wider result; returns {overflow, value}
  function automatic logic [DATA_W:0] sat(input logic [DATA_W:0] s);
    if (s[DATA_W] != s[DATA_W-1]) begin
      return {1'b1, (s[DATA_W] ? RAW_MIN : RAW_MAX)};
    end
    return {1'b0, s[DATA_W-1:0]};
  endfunction

  always_comb begin
    cmd  = cmd_e'(command_i);
    sum  = {operand_a_i[DATA_W-1], operand_a_i} + {operand_b_i[DATA_W-1], operand_b_i};
    diff = {operand_a_i[DATA_W-1], operand_a_i} - {operand_b_i[DATA_W-1], operand_b_i};
    incr = {operand_a_i[DATA_W-1], operand_a_i} + (DATA_W+1)'(1);
    decr = {operand_a_i[DATA_W-1], operand_a_i} - (DATA_W+1)'(1);
    top  = operand_a_i[DATA_W-1 -: FRACTION_BITS+1];

    item_o       = '0;
    item_o.kind  = KIND_SIMPLE;
    item_o.lt    = operand_a_i < operand_b_i;
    item_o.eq    = operand_a_i == operand_b_i;
    item_o.gt    = operand_a_i > operand_b_i;
    item_o.neg   = operand_a_i[DATA_W-1] ^ operand_b_i[DATA_W-1];
    item_o.a_mag = operand_a_i[DATA_W-1] ? (~operand_a_i + DATA_W'(1)) : operand_a_i;
    item_o.b_mag = operand_b_i[DATA_W-1] ? (~operand_b_i + DATA_W'(1)) : operand_b_i;

    case (cmd)
      CMD_ADD: {item_o.ovf, item_o.res} = sat(sum);
      CMD_SUB: {item_o.ovf, item_o.res} = sat(diff);
      CMD_INC: {item_o.ovf, item_o.res} = sat(incr);
      CMD_DEC: {item_o.ovf, item_o.res} = sat(decr);
      CMD_MUL: item_o.kind = KIND_MUL;
      CMD_DIV: begin
        if (operand_b_i == '0) begin
          item_o.dz  = 1'b1;
          item_o.res = operand_a_i[DATA_W-1] ? RAW_MIN : RAW_MAX;
        end else begin
          item_o.kind = KIND_DIV;
        end
      end
      CMD_MIN: item_o.res = (operand_a_i <= operand_b_i) ? operand_a_i : operand_b_i;
      CMD_MAX: item_o.res = (operand_a_i >= operand_b_i) ? operand_a_i : operand_b_i;
      CMD_FROM_INT: begin
        if ((&top) || !(|top)) begin
          item_o.res = operand_a_i << FRACTION_BITS;
        end else begin
          item_o.ovf = 1'b1;
          item_o.res = operand_a_i[DATA_W-1] ? RAW_MIN : RAW_MAX;
        end
      end
      CMD_TO_INT: item_o.res = operand_a_i >>> FRACTION_BITS;
      default: item_o.res = '0;
    endcase
  end

endmodule

// ----- rtl/fpa_queue.sv -----
// Short queue of classified requests between front and back.
module fpa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpa_pkg::item_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fpa_pkg::item_t rdata_o
);
  import fpa_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d;
  logic [QPTR_W-1:0]   rptr_q, rptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d  = do_push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + QPTR_W'(1) : rptr_q;
    count_d = count_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/fpa_back.sv -----
// Back end: multiplier, pipelined divider, rounding, saturation and result register.
module fpa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  fpa_pkg::item_t q_item_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fpa_pkg::res_t  res_o
);
  import fpa_pkg::*;

  pipe_t             pipe_q [DIV_STAGES+1];
  pipe_t             first_d;
  res_t              out_q, out_d;
  logic              out_valid_q;
  logic              adv;
  pipe_t             last;
  logic [PROD_W-1:0] mul_m;
  logic [QUOT_W:0]   div_r;
  logic [PROD_W-1:0] mag;
  logic              ovf_m;

  // Hold the whole pipeline while a result waits untaken
  assign adv     = !out_valid_q || pop_i;
  assign q_pop_o = adv && !q_empty_i;
  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

  // Multiply magnitudes and load the divider
  always_comb begin
    first_d       = '0;
    first_d.valid = q_pop_o;
    first_d.kind  = q_item_i.kind;
    first_d.res   = q_item_i.res;
    first_d.ovf   = q_item_i.ovf;
    first_d.dz    = q_item_i.dz;
    first_d.lt    = q_item_i.lt;
    first_d.eq    = q_item_i.eq;
    first_d.gt    = q_item_i.gt;
    first_d.neg   = q_item_i.neg;
    first_d.prod  = PROD_W'(q_item_i.a_mag) * PROD_W'(q_item_i.b_mag);
    first_d.rem   = '0;
    first_d.dq    = {q_item_i.a_mag, (FRACTION_BITS+1)'(0)};
    first_d.d     = q_item_i.b_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q[0].valid <= 1'b0;
    end else if (adv) begin
      pipe_q[0] <= first_d;
    end
  end

  // Restoring division, a few quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    pipe_t             nxt;
    logic [DATA_W-1:0] sh;
    logic              ge;

    always_comb begin
      nxt = pipe_q[s];
      sh  = '0;
      ge  = 1'b0;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (s * DIV_STEP + j < QUOT_W) begin
          sh      = {nxt.rem[DATA_W-2:0], nxt.dq[QUOT_W-1]};
          ge      = sh >= nxt.d;
          nxt.rem = ge ? sh - nxt.d : sh;
          nxt.dq  = {nxt.dq[QUOT_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[s+1].valid <= 1'b0;
      end else if (adv) begin
        pipe_q[s+1] <= nxt;
      end
    end
  end

  // Round, apply sign and saturate
  always_comb begin
    last  = pipe_q[DIV_STAGES];
    mul_m = (last.prod + HALF_LSB) >> FRACTION_BITS;
    div_r = ({1'b0, last.dq} + (QUOT_W+1)'(1)) >> 1;
    mag   = (last.kind == KIND_MUL) ? mul_m : PROD_W'(div_r);
    ovf_m = last.neg ? (mag > MAG_MIN) : (mag > MAG_MAX);

    out_d     = '0;
    out_d.lt  = last.lt;
    out_d.eq  = last.eq;
    out_d.gt  = last.gt;
    out_d.dz  = last.dz;
    case (last.kind)
      KIND_MUL, KIND_DIV: begin
        out_d.ovf = ovf_m;
        if (ovf_m) begin
          out_d.value = last.neg ? RAW_MIN : RAW_MAX;
        end else begin
          out_d.value = last.neg ? (~mag[DATA_W-1:0] + DATA_W'(1)) : mag[DATA_W-1:0];
        end
      end
      default: begin
        out_d.ovf   = last.ovf;
        out_d.value = last.res;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/fixed_point_alu.sv -----
// Top level of the signed Q24.8 fixed-point arithmetic unit.
//
// Requests are pushed into a queue-like port (push_i / full_o) and results come
// out of another (empty_o / pop_i), one result per request, in order. The unit
// takes one request per cycle for every command while results are popped; an
// untaken result holds the whole pipeline. A request passes the queue, the first
// back register, the divider pipeline, which resolves two quotient bits per
// stage, and the result register. All commands travel through the same
// pipeline, so results never reorder. A two-entry queue between the decoding
// front and the arithmetic back lets push continue for a while when pop stalls.
module fixed_point_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [3:0]                        command_i,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_b_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [fpa_pkg::DATA_W-1:0] result_value_o,
  output logic                              less_than_o,
  output logic                              equal_to_o,
  output logic                              greater_than_o,
  output logic                              overflow_o,
  output logic                              divide_by_zero_o
);
  import fpa_pkg::*;

  item_t front_item;
  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  res_t  res;

  fpa_front u_front (
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .item_o      (front_item)
  );

  fpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (front_item),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_item)
  );

  fpa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .res_o     (res)
  );

  assign result_value_o   = res.value;
  assign less_than_o      = res.lt;
  assign equal_to_o       = res.eq;
  assign greater_than_o   = res.gt;
  assign overflow_o       = res.ovf;
  assign divide_by_zero_o = res.dz;

  // Exactly one compare flag on every result
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> $onehot({less_than_o, equal_to_o, greater_than_o}))
    else $error("compare flags not one-hot");

  // Divide by zero never also reports overflow
  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && divide_by_zero_o |-> !overflow_o)
    else $error("divide by zero with overflow");

  // A saturated result sits at one of the bounds
  a_ovf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && overflow_o |-> (result_value_o == RAW_MAX) || (result_value_o == RAW_MIN))
    else $error("overflow without saturated value");

endmodule
